// File: hw/rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg: shared types and constants of the postfix stack evaluator
// Token codes, status codes, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int OP_W    = 5;
  localparam int VAL_W   = 32;
  localparam int ID_W    = 6;
  localparam int STAT_W  = 3;
  localparam int ENTRY_W = 1 + ID_W + VAL_W;
  localparam int DIV_STEPS = 48;
  localparam int DIV_CNT_W = 6;

  // Token codes.
  localparam logic [OP_W-1:0] OP_NUM    = 5'd0;
  localparam logic [OP_W-1:0] OP_VAR    = 5'd1;
  localparam logic [OP_W-1:0] OP_END    = 5'd2;
  localparam logic [OP_W-1:0] OP_NEG    = 5'd3;
  localparam logic [OP_W-1:0] OP_NOT    = 5'd4;
  localparam logic [OP_W-1:0] OP_ADD    = 5'd5;
  localparam logic [OP_W-1:0] OP_SUB    = 5'd6;
  localparam logic [OP_W-1:0] OP_MUL    = 5'd7;
  localparam logic [OP_W-1:0] OP_DIV    = 5'd8;
  localparam logic [OP_W-1:0] OP_LT     = 5'd9;
  localparam logic [OP_W-1:0] OP_GT     = 5'd10;
  localparam logic [OP_W-1:0] OP_GE     = 5'd11;
  localparam logic [OP_W-1:0] OP_LE     = 5'd12;
  localparam logic [OP_W-1:0] OP_EQ     = 5'd13;
  localparam logic [OP_W-1:0] OP_NE     = 5'd14;
  localparam logic [OP_W-1:0] OP_AND    = 5'd15;
  localparam logic [OP_W-1:0] OP_OR     = 5'd16;
  localparam logic [OP_W-1:0] OP_ASSIGN = 5'd17;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_UNDER   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_OVER    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_ASSIGN  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_DIVZERO = 3'd4;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd5;

  localparam logic signed [VAL_W-1:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_SYM, S_EXEC, S_OP, S_MUL, S_DIV, S_END
  } state_t;

  typedef enum logic [1:0] {
    SRC_ALU, SRC_MUL, SRC_DIV
  } src_t;

  typedef struct packed {
    logic accept;
    logic rd_stack;
    logic rd_sym;
    logic load_opnd;
    logic mul_load;
    logic div_start;
    logic commit;
    src_t commit_src;
    logic end_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ignore;
    logic is_end;
    logic is_mul;
    logic is_div;
    logic fault;
    logic div_done;
    logic out_free;
  } dp_stat_t;

  // Clamp a 33-bit sum or difference to the signed 32-bit range.
  function automatic logic signed [VAL_W-1:0] sat33(input logic [VAL_W:0] v);
    logic signed [VAL_W-1:0] r;
    if (v[VAL_W] != v[VAL_W-1]) begin
      r = v[VAL_W] ? VAL_MIN : VAL_MAX;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] truth(input logic b);
    return b ? Q_ONE : '0;
  endfunction

endpackage

// File: hw/rtl/pse_ram.sv
// ----------------------------------------------------------------------------
// pse_ram: generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: hw/rtl/pse_div.sv
// ----------------------------------------------------------------------------
// pse_div: iterative divider
// Restoring division of a 48-bit magnitude by a 32-bit magnitude, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module pse_div
  import pse_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [DIV_STEPS-1:0]   dividend,
  input  logic [VAL_W-1:0]       divisor,
  output logic                   done,
  output logic [DIV_STEPS-1:0]   quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [VAL_W-1:0]     rem;
  logic [VAL_W-1:0]     dvs;
  logic [VAL_W:0]       shifted;
  logic [VAL_W:0]       trial;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign shifted = {rem, quotient[DIV_STEPS-1]};
  assign trial   = shifted - {1'b0, dvs};

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - DIV_CNT_W'(1);
      end
    end
  end

  // Remainder and quotient registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!trial[VAL_W]) begin
        rem      <= trial[VAL_W-1:0];
        quotient <= {quotient[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem      <= shifted[VAL_W-1:0];
        quotient <= {quotient[DIV_STEPS-2:0], 1'b0};
      end
    end
  end

endmodule

// File: hw/rtl/pse_ctrl.sv
// ----------------------------------------------------------------------------
// pse_ctrl: token sequencer
// Steps each token through stack read, symbol read, operand load and
// execution, drops ignored tokens, and waits for the multiplier, divider or output register.
// ----------------------------------------------------------------------------
module pse_ctrl
  import pse_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  dp_stat_t  stat,
  output logic      in_stall,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.commit_src = SRC_ALU;
    in_stall       = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (stat.ignore) begin
          state_next = S_IDLE;
        end else begin
          cmd.rd_stack = 1'b1;
          state_next   = S_SYM;
        end
      end
      S_SYM: begin
        cmd.rd_sym = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.load_opnd = 1'b1;
        state_next    = S_OP;
      end
      S_OP: begin
        if (stat.is_end) begin
          state_next = S_END;
        end else if (!stat.fault && stat.is_mul) begin
          cmd.mul_load = 1'b1;
          state_next   = S_MUL;
        end else if (!stat.fault && stat.is_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.commit     = 1'b1;
        cmd.commit_src = SRC_MUL;
        state_next     = S_IDLE;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.commit     = 1'b1;
          cmd.commit_src = SRC_DIV;
          state_next     = S_IDLE;
        end
      end
      S_END: begin
        if (stat.out_free) begin
          cmd.end_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/pse_datapath.sv
// ----------------------------------------------------------------------------
// pse_datapath: evaluator datapath
// Operand stack, symbol table, ALU, multiplier, divider and the output
// register, driven by commands from the sequencer.
// ----------------------------------------------------------------------------
module pse_datapath
  import pse_pkg::*;
#(
  parameter int STACK_DEPTH  = 16,
  parameter int SYMBOL_COUNT = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ctrl_cmd_t                cmd,
  output dp_stat_t                 stat,
  input  logic [OP_W-1:0]          op,
  input  logic signed [VAL_W-1:0]  number,
  input  logic [ID_W-1:0]          ident,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VAL_W-1:0]  value,
  output logic                     top_is_variable,
  output logic [ID_W-1:0]          top_ident,
  output logic [STAT_W-1:0]        status
);

  localparam int SIW   = $clog2(STACK_DEPTH);
  localparam int SPW   = $clog2(STACK_DEPTH + 1);
  localparam int ID_N  = 2 ** ID_W;
  localparam int SYM_N = (SYMBOL_COUNT < ID_N) ? SYMBOL_COUNT : ID_N;
  localparam int SYW   = $clog2(SYM_N);

  // Token and control registers.
  logic [OP_W-1:0]         op_r;
  logic signed [VAL_W-1:0] num_r;
  logic [ID_W-1:0]         id_r;
  logic [SPW-1:0]          sp;
  logic [STAT_W-1:0]       err;
  logic [SYM_N-1:0]        sym_valid;

  // Operand registers.
  logic signed [VAL_W-1:0] a_r;
  logic signed [VAL_W-1:0] b_r;
  logic                    l_var;
  logic [ID_W-1:0]         l_id;
  logic                    t_var;
  logic [ID_W-1:0]         t_id;
  logic signed [2*VAL_W-1:0] prod_r;

  // Memory ports.
  logic               stk_we;
  logic [SIW-1:0]     stk_waddr;
  logic [ENTRY_W-1:0] stk_wdata;
  logic [ENTRY_W-1:0] stk_top;
  logic [ENTRY_W-1:0] stk_sec;
  logic [SPW-1:0]     sp_m1;
  logic [SPW-1:0]     sp_m2;
  logic               sym_we;
  logic [VAL_W-1:0]   sym_top;
  logic [VAL_W-1:0]   sym_sec;

  // Operand decode and execution.
  logic                    top_in;
  logic                    sec_in;
  logic                    l_in;
  logic signed [VAL_W-1:0] top_val;
  logic signed [VAL_W-1:0] sec_val;
  logic [STAT_W-1:0]       fault_code;
  logic signed [VAL_W-1:0] alu_r;
  logic signed [VAL_W-1:0] mul_sat;
  logic signed [VAL_W-1:0] div_sat;
  logic signed [VAL_W-1:0] res;
  logic signed [2*VAL_W-1:0] prod_sh;
  logic [VAL_W-1:0]        a_abs;
  logic [VAL_W-1:0]        b_abs;
  logic                    q_neg;
  logic                    div_done;
  logic [DIV_STEPS-1:0]    quot;
  logic                    do_write;
  logic                    out_free;

  assign sp_m1 = sp - SPW'(1);
  assign sp_m2 = sp - SPW'(2);

  pse_ram #(.WIDTH(ENTRY_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .we      (stk_we),
    .waddr   (stk_waddr),
    .wdata   (stk_wdata),
    .re      (cmd.rd_stack),
    .raddr_a (sp_m1[SIW-1:0]),
    .raddr_b (sp_m2[SIW-1:0]),
    .rdata_a (stk_top),
    .rdata_b (stk_sec)
  );

  pse_ram #(.WIDTH(VAL_W), .DEPTH(SYM_N)) u_sym (
    .clk     (clk),
    .we      (sym_we),
    .waddr   (l_id[SYW-1:0]),
    .wdata   (b_r),
    .re      (cmd.rd_sym),
    .raddr_a (stk_top[VAL_W+SYW-1:VAL_W]),
    .raddr_b (stk_sec[VAL_W+SYW-1:VAL_W]),
    .rdata_a (sym_top),
    .rdata_b (sym_sec)
  );

  // A reference beyond the table or never assigned reads zero.
  assign top_in = (int'(stk_top[VAL_W+ID_W-1:VAL_W]) < SYM_N);
  assign sec_in = (int'(stk_sec[VAL_W+ID_W-1:VAL_W]) < SYM_N);
  assign l_in   = (int'(l_id) < SYM_N);

  always_comb begin
    top_val = stk_top[VAL_W-1:0];
    if (stk_top[ENTRY_W-1]) begin
      top_val = (top_in && sym_valid[stk_top[VAL_W+SYW-1:VAL_W]]) ? sym_top : '0;
    end
    sec_val = stk_sec[VAL_W-1:0];
    if (stk_sec[ENTRY_W-1]) begin
      sec_val = (sec_in && sym_valid[stk_sec[VAL_W+SYW-1:VAL_W]]) ? sym_sec : '0;
    end
  end

  // Token capture and operand registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= op;
      num_r <= number;
      id_r  <= ident;
    end
    if (cmd.load_opnd) begin
      a_r   <= sec_val;
      b_r   <= top_val;
      l_var <= stk_sec[ENTRY_W-1];
      l_id  <= stk_sec[VAL_W+ID_W-1:VAL_W];
      t_var <= stk_top[ENTRY_W-1];
      t_id  <= stk_top[VAL_W+ID_W-1:VAL_W];
    end
    if (cmd.mul_load) begin
      prod_r <= a_r * b_r;
    end
  end

  // Error detection for the current token.
  always_comb begin
    fault_code = STAT_OK;
    case (op_r) inside
      OP_NUM, OP_VAR: begin
        if (sp == SPW'(STACK_DEPTH)) fault_code = STAT_OVER;
      end
      OP_NEG, OP_NOT: begin
        if (sp == '0) fault_code = STAT_UNDER;
      end
      [OP_ADD:OP_ASSIGN]: begin
        if (sp < SPW'(2)) begin
          fault_code = STAT_UNDER;
        end else if (op_r == OP_DIV && b_r == '0) begin
          fault_code = STAT_DIVZERO;
        end else if (op_r == OP_ASSIGN && !l_var) begin
          fault_code = STAT_ASSIGN;
        end
      end
      default: ;
    endcase
  end

  // Combinational operators.
  always_comb begin
    case (op_r)
      OP_NEG: alu_r = sat33(-{b_r[VAL_W-1], b_r});
      OP_NOT: alu_r = truth(b_r == '0);
      OP_ADD: alu_r = sat33({a_r[VAL_W-1], a_r} + {b_r[VAL_W-1], b_r});
      OP_SUB: alu_r = sat33({a_r[VAL_W-1], a_r} - {b_r[VAL_W-1], b_r});
      OP_LT:  alu_r = truth(a_r < b_r);
      OP_GT:  alu_r = truth(a_r > b_r);
      OP_GE:  alu_r = truth(a_r >= b_r);
      OP_LE:  alu_r = truth(a_r <= b_r);
      OP_EQ:  alu_r = truth(a_r == b_r);
      OP_NE:  alu_r = truth(a_r != b_r);
      OP_AND: alu_r = truth(a_r != '0 && b_r != '0);
      OP_OR:  alu_r = truth(a_r != '0 || b_r != '0);
      default: alu_r = '0;
    endcase
  end

  // Product scaled back to Q16.16, rounding toward minus infinity.
  assign prod_sh = prod_r >>> 16;
  always_comb begin
    if (prod_sh > 64'sh0000_0000_7FFF_FFFF) begin
      mul_sat = VAL_MAX;
    end else if (prod_sh < -64'sh0000_0000_8000_0000) begin
      mul_sat = VAL_MIN;
    end else begin
      mul_sat = prod_sh[VAL_W-1:0];
    end
  end

  // Divider on magnitudes; the sign is applied to the quotient.
  assign a_abs = a_r[VAL_W-1] ? VAL_W'(-a_r) : VAL_W'(a_r);
  assign b_abs = b_r[VAL_W-1] ? VAL_W'(-b_r) : VAL_W'(b_r);
  assign q_neg = a_r[VAL_W-1] ^ b_r[VAL_W-1];

  pse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({a_abs, 16'd0}),
    .divisor  (b_abs),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    if (q_neg) begin
      div_sat = (quot > DIV_STEPS'(64'h8000_0000)) ? VAL_MIN : VAL_W'(-quot[VAL_W-1:0]);
    end else begin
      div_sat = (quot > DIV_STEPS'(64'h7FFF_FFFF)) ? VAL_MAX : quot[VAL_W-1:0];
    end
  end

  always_comb begin
    case (cmd.commit_src)
      SRC_MUL: res = mul_sat;
      SRC_DIV: res = div_sat;
      default: res = alu_r;
    endcase
  end

  // Stack and symbol table writes at commit.
  assign do_write = cmd.commit && !(cmd.commit_src == SRC_ALU && fault_code != STAT_OK);

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = sp[SIW-1:0];
    stk_wdata = {1'b0, {ID_W{1'b0}}, num_r};
    sym_we    = 1'b0;
    if (do_write) begin
      case (op_r) inside
        OP_NUM: begin
          stk_we = 1'b1;
        end
        OP_VAR: begin
          stk_we    = 1'b1;
          stk_wdata = {1'b1, id_r, {VAL_W{1'b0}}};
        end
        OP_NEG, OP_NOT: begin
          stk_we    = 1'b1;
          stk_waddr = sp_m1[SIW-1:0];
          stk_wdata = {1'b0, {ID_W{1'b0}}, res};
        end
        [OP_ADD:OP_OR]: begin
          stk_we    = 1'b1;
          stk_waddr = sp_m2[SIW-1:0];
          stk_wdata = {1'b0, {ID_W{1'b0}}, res};
        end
        OP_ASSIGN: begin
          sym_we = l_in;
        end
        default: ;
      endcase
    end
  end

  // Stack pointer, sticky error and symbol valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      sp        <= '0;
      err       <= STAT_OK;
      sym_valid <= '0;
    end else begin
      if (cmd.end_load) begin
        sp  <= '0;
        err <= STAT_OK;
      end else if (cmd.commit) begin
        if (!do_write) begin
          err <= fault_code;
        end else begin
          case (op_r) inside
            OP_NUM, OP_VAR:         sp <= sp + SPW'(1);
            [OP_ADD:OP_ASSIGN]:     sp <= sp_m1;
            default: ;
          endcase
        end
      end
      if (sym_we) begin
        sym_valid[l_id[SYW-1:0]] <= 1'b1;
      end
    end
  end

  // Output register.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.end_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.end_load) begin
      value           <= '0;
      top_is_variable <= 1'b0;
      top_ident       <= '0;
      if (err != STAT_OK) begin
        status <= err;
      end else if (sp == '0) begin
        status <= STAT_EMPTY;
      end else begin
        status          <= STAT_OK;
        value           <= b_r;
        top_is_variable <= t_var;
        top_ident       <= t_var ? t_id : '0;
      end
    end
  end

  // Status toward the sequencer.
  assign stat.ignore   = (op_r > OP_ASSIGN) || (err != STAT_OK && op_r != OP_END);
  assign stat.is_end   = (op_r == OP_END);
  assign stat.is_mul   = (op_r == OP_MUL);
  assign stat.is_div   = (op_r == OP_DIV);
  assign stat.fault    = (fault_code != STAT_OK);
  assign stat.div_done = div_done;
  assign stat.out_free = out_free;

endmodule

// File: hw/rtl/postfix_stack_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator: Q16.16 postfix expression evaluator
// Takes one postfix token per word and returns one result word per end token.
// ----------------------------------------------------------------------------
// Tokens are handled one at a time. A number, variable, negate, not or
// combinational binary operator passes through accept, stack read, symbol
// read, operand load and execute before the next token can be taken, since
// the stack and symbol table are RAMs with registered reads. Multiply also
// waits for the registered product, and divide waits for the 48-step
// one-bit-per-cycle divider. An end token passes through the same steps
// and then waits while the previous result sits in the output register.
// The symbol table is cleared at reset through per-entry valid bits, so no
// clearing pass is needed and tokens are accepted right after reset.
module postfix_stack_evaluator
  import pse_pkg::*;
#(
  parameter int STACK_DEPTH  = 16,
  parameter int SYMBOL_COUNT = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         op,
  input  logic signed [VAL_W-1:0] number,
  input  logic [ID_W-1:0]         ident,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] value,
  output logic                    top_is_variable,
  output logic [ID_W-1:0]         top_ident,
  output logic [STAT_W-1:0]       status
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  pse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  pse_datapath #(
    .STACK_DEPTH  (STACK_DEPTH),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .op              (op),
    .number          (number),
    .ident           (ident),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .value           (value),
    .top_is_variable (top_is_variable),
    .top_ident       (top_ident),
    .status          (status)
  );

  // A result is loaded only into a free output register.
  assert property (@(posedge clk) disable iff (rst) cmd.end_load |-> stat.out_free)
    else $error("result loaded while output register occupied");

  // An accepted word keeps the input side stalled in the next cycle.
  assert property (@(posedge clk) disable iff (rst) (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting a word");

  // Commit and end handling never happen together.
  assert property (@(posedge clk) disable iff (rst) !(cmd.commit && cmd.end_load))
    else $error("commit and end load in the same cycle");

endmodule
